>>> hw/rtl/msfp_pkg.sv
// Shared types and constants for the sync-word frame parser.
package msfp_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'h54;
	localparam logic [7:0] SYNC_SECOND  = 8'h42;
	localparam logic [2:0] HDR_LAST_IDX = 3'd7;

	localparam logic [2:0] HDR_IDX_TYPE  = 3'd0;
	localparam logic [2:0] HDR_IDX_FLAGS = 3'd1;
	localparam logic [2:0] HDR_IDX_LEN0  = 3'd2;
	localparam logic [2:0] HDR_IDX_LEN1  = 3'd3;
	localparam logic [2:0] HDR_IDX_SEQ0  = 3'd4;
	localparam logic [2:0] HDR_IDX_SEQ1  = 3'd5;
	localparam logic [2:0] HDR_IDX_SEQ2  = 3'd6;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_SYNC2   = 4'b0010,
		PH_HEADER  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        is_header;
		logic [7:0]  msg_type;
		logic [7:0]  frame_flags;
		logic [15:0] payload_length;
		logic [31:0] sequence_res;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_stage_t;

endpackage

>>> hw/rtl/msfp_in_stage.sv
// Input register that holds one received byte until the parser takes it.
module msfp_in_stage
	import msfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        advance,
	output byte_stage_t s1
);

	logic       valid_s1;
	logic [7:0] data_s1;

	// stall only while a held byte cannot move on
	assign in_stall = valid_s1 && !advance;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.data  = data_s1;

endmodule

>>> hw/rtl/msfp_core.sv
// Frame state, registered result; a byte per cycle unless stalled.
module msfp_core
	import msfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  byte_stage_t s1,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  flags_q, flags_d;
	logic [15:0] len_q, len_d;
	logic [31:0] seq_q, seq_d;
	logic [15:0] left_q, left_d;
	logic        has_res;
	result_t     res_d;
	result_t     res_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	// decode the held byte against the frame state
	always_comb begin
		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		type_d    = type_q;
		flags_d   = flags_q;
		len_d     = len_q;
		seq_d     = seq_q;
		left_d    = left_q;
		has_res   = 1'b0;
		res_d     = '0;
		case (phase_q)
			PH_HUNT: begin
				if (s1.data == SYNC_FIRST) begin
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (s1.data == SYNC_SECOND) begin
					phase_d   = PH_HEADER;
					hdr_idx_d = '0;
				end else if (s1.data != SYNC_FIRST) begin
					phase_d = PH_HUNT;
				end
			end
			PH_HEADER: begin
				case (hdr_idx_q)
					HDR_IDX_TYPE:  type_d        = s1.data;
					HDR_IDX_FLAGS: flags_d       = s1.data;
					HDR_IDX_LEN0:  len_d[7:0]    = s1.data;
					HDR_IDX_LEN1:  len_d[15:8]   = s1.data;
					HDR_IDX_SEQ0:  seq_d[7:0]    = s1.data;
					HDR_IDX_SEQ1:  seq_d[15:8]   = s1.data;
					HDR_IDX_SEQ2:  seq_d[23:16]  = s1.data;
					default:       seq_d[31:24]  = s1.data;
				endcase
				if (hdr_idx_q != HDR_LAST_IDX) begin
					hdr_idx_d = hdr_idx_q + 3'd1;
				end else begin
					hdr_idx_d = '0;
					has_res   = 1'b1;
					res_d.is_header = 1'b1;
					if (len_d == 16'd0) begin
						res_d.last = 1'b1;
						phase_d    = PH_HUNT;
					end else begin
						left_d  = len_d;
						phase_d = PH_PAYLOAD;
					end
				end
			end
			default: begin
				has_res            = 1'b1;
				res_d.payload_byte = s1.data;
				if (left_q <= 16'd1) begin
					res_d.last = 1'b1;
					left_d     = '0;
					phase_d    = PH_HUNT;
				end else begin
					left_d = left_q - 16'd1;
				end
			end
		endcase
		res_d.msg_type       = type_d;
		res_d.frame_flags    = flags_d;
		res_d.payload_length = len_d;
		res_d.sequence_res   = seq_d;
	end

	// move the byte on unless its result would overrun a waiting one
	assign advance = s1.valid && (!has_res || out_free);

	// advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_idx_q <= '0;
			type_q    <= '0;
			flags_q   <= '0;
			len_q     <= '0;
			seq_q     <= '0;
			left_q    <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			type_q    <= type_d;
			flags_q   <= flags_d;
			len_q     <= len_d;
			seq_q     <= seq_d;
			left_q    <= left_d;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/magic_sync_frame_parser_unit.sv
// A byte is held in the input register and its result is registered in the output register.
// Throughput: one byte per cycle unless a byte's result meets a stalled result in the output register.
// A result waiting in the output register does not block bytes that give none.
// Reset (arst_n low, asynchronous): hunt for the sync word, header fields
// cleared, input and output registers empty.
// Top level of the sync-word frame parser.
module magic_sync_frame_parser_unit
	import msfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_header,
	output logic [7:0]  msg_type,
	output logic [7:0]  frame_flags,
	output logic [15:0] payload_length,
	output logic [31:0] sequence_res,
	output logic [7:0]  payload_byte,
	output logic        last
);

	byte_stage_t s1;
	logic        advance;
	result_t     res;

	msfp_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.advance   (advance),
		.s1        (s1)
	);

	msfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// unpack the result fields
	assign is_header      = res.is_header;
	assign msg_type       = res.msg_type;
	assign frame_flags    = res.frame_flags;
	assign payload_length = res.payload_length;
	assign sequence_res   = res.sequence_res;
	assign payload_byte   = res.payload_byte;
	assign last           = res.last;

endmodule
